[src/lvq_pkg.sv]
// ----------------------------------------------------------------------------
// lvq_pkg
// Shared constants, op codes and lane control type for the LVQ1 trainer.
// ----------------------------------------------------------------------------
package lvq_pkg;

  localparam int LVQ_DIMS       = 6;
  localparam int LVQ_PROTOS     = 2;
  localparam int FEATURE_FIELDS = 6;

  localparam int FEAT_W  = 8;
  localparam int FRAC_W  = 8;
  localparam int W_W     = 16;
  localparam int RATE_W  = 16;
  localparam int Q_SHIFT = 16;
  localparam int DIST_OUT_W = 19;
  localparam int OP_W    = 2;

  localparam logic [RATE_W-1:0] LR_INIT_RST = 16'd3277;
  localparam logic [RATE_W-1:0] KEEP_RST    = 16'd58982;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_LR_INIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP    = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_TRAIN    = 2'd0,
    OP_CLASSIFY = 2'd1,
    OP_EPOCH    = 2'd2,
    OP_LOAD     = 2'd3
  } op_t;

  typedef struct packed {
    logic clear;
    logic dist_en;
    logic upd_en;
    logic load;
    logic toward;
  } lane_ctrl_t;

endpackage

[src/lvq_lane.sv]
// ----------------------------------------------------------------------------
// lvq_lane
// One prototype: weight registers, one shared multiplier, distance
// accumulator and the saturating weight update.
// ----------------------------------------------------------------------------
module lvq_lane import lvq_pkg::*; #(
  parameter int DIMS  = LVQ_DIMS,
  parameter int DIM_W = 3,
  parameter int SUM_W = 35
) (
  input  logic              clk,
  input  logic              rst,
  input  lane_ctrl_t        ctrl,
  input  logic              sel,
  input  logic [DIM_W-1:0]  dim,
  input  logic [FEAT_W-1:0] feat [DIMS],
  input  logic [RATE_W-1:0] rate,
  output logic [SUM_W-1:0]  sq_dist
);

  localparam int PROD_W = 2 * W_W;
  localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (W_W - 1);

  logic [W_W-1:0]    w [DIMS];
  logic [W_W-1:0]    x_cur;
  logic [W_W-1:0]    w_cur;
  logic [W_W-1:0]    mag;
  logic [W_W-1:0]    mult_b;
  logic              neg;
  logic [PROD_W-1:0] prod;
  logic              prod_v;
  logic              upd_v;
  logic              upd_neg;
  logic [DIM_W-1:0]  upd_dim;
  logic [W_W-1:0]    w_old;
  logic [SUM_W-1:0]  acc;
  logic [PROD_W:0]   rnd;
  logic [W_W:0]      step;
  logic [W_W+1:0]    wsum;
  logic              add;
  logic [W_W-1:0]    w_next;

  always_comb begin
    x_cur  = {feat[dim], {FRAC_W{1'b0}}};
    w_cur  = w[dim];
    neg    = x_cur < w_cur;
    mag    = neg ? (w_cur - x_cur) : (x_cur - w_cur);
    mult_b = ctrl.upd_en ? rate : mag;
  end

  // round to nearest, then move toward or away with saturation
  always_comb begin
    rnd  = {1'b0, prod} + ROUND_HALF;
    step = rnd[PROD_W:W_W];
    add  = ctrl.toward ^ upd_neg;
    wsum = {2'b00, w_old} + {1'b0, step};
    if (add) begin
      w_next = (wsum[W_W+1:W_W] != 2'b00) ? '1 : wsum[W_W-1:0];
    end else begin
      w_next = ({1'b0, w_old} < step) ? '0 : W_W'({1'b0, w_old} - step);
    end
  end

  always_ff @(posedge clk) begin
    prod    <= PROD_W'(mag) * PROD_W'(mult_b);
    upd_dim <= dim;
    upd_neg <= neg;
    w_old   <= w_cur;
    if (rst) begin
      prod_v <= 1'b0;
      upd_v  <= 1'b0;
    end else if (ctrl.clear) begin
      prod_v <= 1'b0;
      upd_v  <= 1'b0;
    end else begin
      prod_v <= ctrl.dist_en;
      upd_v  <= ctrl.upd_en & sel;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + SUM_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load && sel) begin
      for (int d = 0; d < DIMS; d++) begin
        w[d] <= {feat[d], {FRAC_W{1'b0}}};
      end
    end else if (upd_v) begin
      w[upd_dim] <= w_next;
    end
  end

  assign sq_dist = acc;

endmodule

[src/lvq_merge.sv]
// ----------------------------------------------------------------------------
// lvq_merge
// Scans the lane distances in index order and keeps the smallest; ties
// stay with the lower index.
// ----------------------------------------------------------------------------
module lvq_merge import lvq_pkg::*; #(
  parameter int PROTOS = LVQ_PROTOS,
  parameter int PW     = 1,
  parameter int SUM_W  = 35
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] sums [PROTOS],
  output logic             done,
  output logic [PW-1:0]    win,
  output logic [SUM_W-1:0] best
);

  logic          busy;
  logic [PW-1:0] idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= PW'(1);
        best <= sums[0];
        win  <= '0;
      end else if (busy) begin
        if (sums[idx] < best) begin
          best <= sums[idx];
          win  <= idx;
        end
        if (idx == PW'(PROTOS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          idx <= idx + PW'(1);
        end
      end
    end
  end

endmodule

[src/lvq_nearest_prototype_trainer.sv]
// ----------------------------------------------------------------------------
// lvq_nearest_prototype_trainer
// LVQ1 engine: nearest prototype search, training update and rate decay.
//
// Input transactions (in_valid/in_ready) carry an op, a feature vector and
// a target class; each one yields exactly one result transaction
// (out_valid/out_ready). Ops: train, classify, end epoch, load prototype.
// One lane per prototype computes its squared distance, one feature per
// cycle through the lane multiplier; a merge stage then scans the lanes.
// Train walks the features for the distances, runs the merge scan and
// walks them again for the update; classify stops after the scan.
// One item is in work at a time; the next is taken in the cycle after
// the previous result is registered, even while that result still waits
// for out_ready. A stalled receiver holds the finished item in its last
// state until the output register frees up.
// Reset clears control state and loads the rate registers with their
// defaults; prototypes must be loaded before they are used.
// ----------------------------------------------------------------------------
module lvq_nearest_prototype_trainer import lvq_pkg::*; #(
  parameter int DIMS   = LVQ_DIMS,
  parameter int PROTOS = LVQ_PROTOS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       op,
  input  logic [FEAT_W-1:0]     feature_0,
  input  logic [FEAT_W-1:0]     feature_1,
  input  logic [FEAT_W-1:0]     feature_2,
  input  logic [FEAT_W-1:0]     feature_3,
  input  logic [FEAT_W-1:0]     feature_4,
  input  logic [FEAT_W-1:0]     feature_5,
  input  logic                  target_class,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  winner_class,
  output logic                  correct,
  output logic [DIST_OUT_W-1:0] min_sq_distance,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DIM_W = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int PW    = $clog2(PROTOS);
  localparam int SUM_W = 2 * W_W + ((DIMS > 1) ? $clog2(DIMS) : 0);
  localparam int RP_W  = 2 * RATE_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_DIST,
    S_DRAIN,
    S_MERGE,
    S_SCAN,
    S_UPD,
    S_UPD_DRAIN,
    S_EPOCH_MUL,
    S_EPOCH_RND,
    S_EMIT
  } state_t;

  state_t              state;
  logic [DIM_W-1:0]    dim;
  op_t                 op_r;
  logic                target_r;
  logic [FEAT_W-1:0]   feat_in  [FEATURE_FIELDS];
  logic [FEAT_W-1:0]   feat_mux [DIMS];
  logic [FEAT_W-1:0]   feat_r   [DIMS];

  logic [RATE_W-1:0]   keep;
  logic [RATE_W-1:0]   rate;
  logic [RP_W-1:0]     rate_prod;
  logic [RP_W:0]       rate_rnd;

  lane_ctrl_t          lane_ctrl;
  logic [PROTOS-1:0]   lane_sel;
  logic [SUM_W-1:0]    lane_dist [PROTOS];

  logic                merge_start;
  logic                merge_done;
  logic [PW-1:0]       merge_win;
  logic [SUM_W-1:0]    merge_best;
  logic                match;
  logic [SUM_W+DIST_OUT_W-1:0] best_ext;

  assign feat_in[0] = feature_0;
  assign feat_in[1] = feature_1;
  assign feat_in[2] = feature_2;
  assign feat_in[3] = feature_3;
  assign feat_in[4] = feature_4;
  assign feat_in[5] = feature_5;

  // features past the input fields read as zero
  for (genvar d = 0; d < DIMS; d++) begin : g_feat
    if (d < FEATURE_FIELDS) begin : g_port
      assign feat_mux[d] = feat_in[d];
    end else begin : g_zero
      assign feat_mux[d] = '0;
    end
  end

  assign in_ready    = (state == S_IDLE);
  assign merge_start = (state == S_MERGE);
  assign match       = (merge_win == PW'(target_r));
  assign best_ext    = (SUM_W + DIST_OUT_W)'(merge_best);

  always_comb begin
    lane_ctrl.clear   = (state == S_IDLE);
    lane_ctrl.dist_en = (state == S_DIST);
    lane_ctrl.upd_en  = (state == S_UPD);
    lane_ctrl.load    = (state == S_LOAD);
    lane_ctrl.toward  = match;
    for (int p = 0; p < PROTOS; p++) begin
      if (state == S_LOAD) begin
        lane_sel[p] = (PW'(p) == PW'(target_r));
      end else begin
        lane_sel[p] = (PW'(p) == merge_win);
      end
    end
  end

  for (genvar p = 0; p < PROTOS; p++) begin : g_lane
    lvq_lane #(
      .DIMS  (DIMS),
      .DIM_W (DIM_W),
      .SUM_W (SUM_W)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (lane_ctrl),
      .sel     (lane_sel[p]),
      .dim     (dim),
      .feat    (feat_r),
      .rate    (rate),
      .sq_dist (lane_dist[p])
    );
  end

  lvq_merge #(
    .PROTOS (PROTOS),
    .PW     (PW),
    .SUM_W  (SUM_W)
  ) u_merge (
    .clk   (clk),
    .rst   (rst),
    .start (merge_start),
    .sums  (lane_dist),
    .done  (merge_done),
    .win   (merge_win),
    .best  (merge_best)
  );

  // config registers and learning rate
  assign rate_rnd = {1'b0, rate_prod} + (RP_W + 1)'(1 << (RATE_W - 1));

  always_ff @(posedge clk) begin
    if (state == S_EPOCH_MUL) begin
      rate_prod <= RP_W'(rate) * RP_W'(keep);
    end
    if (rst) begin
      keep    <= KEEP_RST;
      rate    <= LR_INIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LR_INIT: begin
          rate    <= cfg_data[RATE_W-1:0];
        end
        CFG_KEEP: begin
          keep <= cfg_data[RATE_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (state == S_EPOCH_RND) begin
      rate <= rate_rnd[RP_W-1:RATE_W];
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dim       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= op_t'(op);
            target_r <= target_class;
            feat_r   <= feat_mux;
            dim      <= '0;
            case (op_t'(op))
              OP_TRAIN:    state <= S_DIST;
              OP_CLASSIFY: state <= S_DIST;
              OP_EPOCH:    state <= S_EPOCH_MUL;
              OP_LOAD:     state <= S_LOAD;
              default:     state <= S_IDLE;
            endcase
          end
        end
        S_LOAD: state <= S_EMIT;
        S_DIST: begin
          if (dim == DIM_W'(DIMS - 1)) begin
            state <= S_DRAIN;
          end else begin
            dim <= dim + DIM_W'(1);
          end
        end
        S_DRAIN: state <= S_MERGE;
        S_MERGE: state <= S_SCAN;
        S_SCAN: begin
          if (merge_done) begin
            dim <= '0;
            state <= (op_r == OP_TRAIN) ? S_UPD : S_EMIT;
          end
        end
        S_UPD: begin
          if (dim == DIM_W'(DIMS - 1)) begin
            state <= S_UPD_DRAIN;
          end else begin
            dim <= dim + DIM_W'(1);
          end
        end
        S_UPD_DRAIN: state <= S_EMIT;
        S_EPOCH_MUL: state <= S_EPOCH_RND;
        S_EPOCH_RND: state <= S_EMIT;
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (op_r == OP_TRAIN || op_r == OP_CLASSIFY) begin
              winner_class    <= merge_win[0];
              correct         <= (op_r == OP_TRAIN) && match;
              min_sq_distance <= best_ext[Q_SHIFT +: DIST_OUT_W];
            end else begin
              winner_class    <= 1'b0;
              correct         <= 1'b0;
              min_sq_distance <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    merge_done |-> state == S_SCAN)
    else $error("merge finished outside the scan phase");

  a_one_winner: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD || state == S_LOAD) |-> $onehot(lane_sel))
    else $error("weight write not aimed at exactly one lane");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state != S_IDLE)
    else $error("accepted transaction did not start work");

endmodule

[test/lvq_nearest_prototype_trainer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lvq_nearest_prototype_trainer_tb
// Self-checking bench for the LVQ1 trainer. A directed table loads both
// prototypes and covers ties, distance extremes, weight saturation, epoch
// decay and loads; random phases then mix train, classify, epoch and load
// transactions under several rate settings. Each accepted input is run
// through a local predictor and every result is compared in order.
// ----------------------------------------------------------------------------
module lvq_nearest_prototype_trainer_tb;
  import lvq_pkg::*;

  typedef struct packed {
    logic                  win;
    logic                  ok;
    logic [DIST_OUT_W-1:0] sq_dist;
  } lvq_result_t;

  typedef struct packed {
    op_t                       op;
    logic [5:0][FEAT_W-1:0]    feat;
    logic                      tgt;
    logic                      typed;
    lvq_result_t               exp;
  } lvq_stim_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [OP_W-1:0]       op;
  logic [FEAT_W-1:0]     feature_0, feature_1, feature_2;
  logic [FEAT_W-1:0]     feature_3, feature_4, feature_5;
  logic                  target_class;
  logic                  out_valid;
  logic                  out_ready;
  logic                  winner_class;
  logic                  correct;
  logic [DIST_OUT_W-1:0] min_sq_distance;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lvq_stim_t   cur_item;
  lvq_stim_t   directed_rows[$];
  lvq_result_t pending_results[$];
  int          mismatches;
  int          send_calm;
  int          recv_calm;

  // predictor state
  logic [W_W-1:0]    proto_w [0:LVQ_PROTOS-1][0:LVQ_DIMS-1];
  logic [RATE_W-1:0] rate_q;
  logic [RATE_W-1:0] keep_q;

  assign op           = cur_item.op;
  assign feature_0    = cur_item.feat[0];
  assign feature_1    = cur_item.feat[1];
  assign feature_2    = cur_item.feat[2];
  assign feature_3    = cur_item.feat[3];
  assign feature_4    = cur_item.feat[4];
  assign feature_5    = cur_item.feat[5];
  assign target_class = cur_item.tgt;

  lvq_nearest_prototype_trainer u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .feature_0      (feature_0),
    .feature_1      (feature_1),
    .feature_2      (feature_2),
    .feature_3      (feature_3),
    .feature_4      (feature_4),
    .feature_5      (feature_5),
    .target_class   (target_class),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .winner_class   (winner_class),
    .correct        (correct),
    .min_sq_distance(min_sq_distance),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic lvq_result_t predict_lvq_step(lvq_stim_t s);
    lvq_result_t       r;
    longint unsigned   proto_dist [LVQ_PROTOS];
    longint unsigned   best, mag, step, prod;
    longint            nw;
    int                win;
    logic [W_W-1:0]    x, w;
    logic              neg, toward;
    r = '0;
    if (s.op == OP_LOAD) begin
      for (int d = 0; d < LVQ_DIMS; d++) proto_w[s.tgt][d] = {s.feat[d], 8'h00};
      return r;
    end
    if (s.op == OP_EPOCH) begin
      prod = rate_q;
      prod = (prod * keep_q + 64'd32768) >> 16;
      rate_q = prod[RATE_W-1:0];
      return r;
    end
    for (int p = 0; p < LVQ_PROTOS; p++) begin
      proto_dist[p] = 0;
      for (int d = 0; d < LVQ_DIMS; d++) begin
        x = {s.feat[d], 8'h00};
        w = proto_w[p][d];
        mag = (x >= w) ? longint'(x - w) : longint'(w - x);
        proto_dist[p] += mag * mag;
      end
    end
    best = proto_dist[0];
    win = 0;
    for (int p = 1; p < LVQ_PROTOS; p++) begin
      if (proto_dist[p] < best) begin
        best = proto_dist[p];
        win = p;
      end
    end
    r.win     = win[0];
    r.sq_dist = best[Q_SHIFT +: DIST_OUT_W];
    if (s.op == OP_TRAIN) begin
      toward = (win == int'(s.tgt));
      r.ok = toward;
      for (int d = 0; d < LVQ_DIMS; d++) begin
        x = {s.feat[d], 8'h00};
        w = proto_w[win][d];
        neg = x < w;
        mag = neg ? longint'(w - x) : longint'(x - w);
        prod = rate_q;
        step = (prod * mag + 64'd32768) >> 16;
        if (neg == toward) nw = longint'(w) - longint'(step);
        else nw = longint'(w) + longint'(step);
        if (nw < 0) nw = 0;
        if (nw > 65535) nw = 65535;
        proto_w[win][d] = nw[W_W-1:0];
      end
    end
    return r;
  endfunction

  // scoreboard: predict on input transaction, compare on output transaction
  always @(posedge clk) begin : scoreboard
    lvq_result_t want, got;
    if (!rst) begin
      if (in_valid && in_ready) begin
        want = predict_lvq_step(cur_item);
        if (cur_item.typed) want = cur_item.exp;
        pending_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = '{win: winner_class, ok: correct, sq_dist: min_sq_distance};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction: win=%0d ok=%0d dist=%0d",
                     got.win, got.ok, got.sq_dist);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected win=%0d ok=%0d dist=%0d, got win=%0d ok=%0d dist=%0d",
                       want.win, want.ok, want.sq_dist, got.win, got.ok, got.sq_dist);
          end
        end
      end
    end
  end

  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 99) < 4) calm_left = $urandom_range(8, 40);
    return $urandom_range(0, 16);
  endfunction

  task automatic send_txn(input lvq_stim_t s);
    int gap;
    gap = draw_gap(send_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_item = s;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_for_drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LR_INIT) begin
      rate_q      = val;
    end else begin
      keep_q = val;
    end
  endtask

  function automatic void add_row(op_t o, logic [5:0][FEAT_W-1:0] f, logic t,
                                  logic typed, logic win, logic ok,
                                  logic [DIST_OUT_W-1:0] d_exp);
    lvq_stim_t s;
    s.op    = o;
    s.feat  = f;
    s.tgt   = t;
    s.typed = typed;
    s.exp   = '{win: win, ok: ok, sq_dist: d_exp};
    directed_rows.push_back(s);
  endfunction

  function automatic lvq_stim_t random_item();
    lvq_stim_t s;
    int        r, mode, p, v;
    s = '0;
    r = $urandom_range(0, 99);
    if (r < 50) s.op = OP_TRAIN;
    else if (r < 78) s.op = OP_CLASSIFY;
    else if (r < 86) s.op = OP_EPOCH;
    else s.op = OP_LOAD;
    s.tgt = $urandom_range(0, 1);
    mode = $urandom_range(0, 3);
    p = $urandom_range(0, LVQ_PROTOS - 1);
    for (int d = 0; d < 6; d++) begin
      case (mode)
        0: begin
          v = $urandom_range(0, 1) ? 255 : 0;
        end
        1, 2: begin
          v = int'(proto_w[p][d] >> 8) + $urandom_range(0, 24) - 12;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
        end
        default: begin
          v = $urandom_range(0, 255);
        end
      endcase
      s.feat[d] = v[FEAT_W-1:0];
    end
    return s;
  endfunction

  // receiver: random stall ahead of each output transaction
  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap(recv_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    logic [RATE_W-1:0] phase_init [5];
    logic [RATE_W-1:0] phase_keep [5];
    rst         = 1'b1;
    in_valid    = 1'b0;
    cur_item    = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_LR_INIT;
    cfg_data    = '0;
    mismatches  = 0;
    send_calm   = 0;
    recv_calm   = 0;
    rate_q      = LR_INIT_RST;
    keep_q      = KEEP_RST;
    for (int p = 0; p < LVQ_PROTOS; p++)
      for (int d = 0; d < LVQ_DIMS; d++) proto_w[p][d] = '0;
    phase_init = '{16'hFFFF, 16'h0000, 16'h0000, LR_INIT_RST, 16'hFFFF};
    phase_keep = '{16'hFFFF, 16'h0000, 16'h0000, KEEP_RST, 16'h8000};
    phase_init[2] = $urandom_range(0, 65535);
    phase_keep[2] = $urandom_range(0, 65535);

    // directed table, default rates
    add_row(OP_LOAD, {6{8'd0}}, 1'b0, 1, 0, 0, 0);
    add_row(OP_LOAD, {6{8'd255}}, 1'b1, 1, 0, 0, 0);
    add_row(OP_CLASSIFY, {6{8'd0}}, 1'b1, 1, 0, 0, 0);
    add_row(OP_CLASSIFY, {6{8'd255}}, 1'b0, 1, 1, 0, 0);
    // equal distance to both prototypes goes to prototype 0
    add_row(OP_CLASSIFY, {8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0}, 1'b1, 1, 0, 0, 195075);
    add_row(OP_CLASSIFY, {6{8'd128}}, 1'b0, 0, 0, 0, 0);
    add_row(OP_TRAIN, {6{8'd255}}, 1'b1, 1, 1, 1, 0);
    add_row(OP_TRAIN, {6{8'd0}}, 1'b0, 1, 0, 1, 0);
    // mismatch pushes weights below zero and up past the top
    add_row(OP_TRAIN, {6{8'd10}}, 1'b1, 0, 0, 0, 0);
    add_row(OP_TRAIN, {6{8'd130}}, 1'b0, 0, 0, 0, 0);
    add_row(OP_EPOCH, {6{8'd255}}, 1'b1, 1, 0, 0, 0);
    add_row(OP_EPOCH, {6{8'd0}}, 1'b0, 1, 0, 0, 0);
    add_row(OP_TRAIN, {8'd17, 8'd200, 8'd99, 8'd3, 8'd240, 8'd77}, 1'b1, 0, 0, 0, 0);
    add_row(OP_TRAIN, {8'd120, 8'd5, 8'd250, 8'd64, 8'd33, 8'd190}, 1'b0, 0, 0, 0, 0);
    add_row(OP_LOAD, {8'd32, 8'd16, 8'd8, 8'd4, 8'd2, 8'd1}, 1'b1, 1, 0, 0, 0);
    add_row(OP_LOAD, {8'd223, 8'd239, 8'd247, 8'd251, 8'd253, 8'd254}, 1'b0, 1, 0, 0, 0);
    add_row(OP_CLASSIFY, {8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255}, 1'b0, 0, 0, 0, 0);
    add_row(OP_TRAIN, {8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32}, 1'b0, 0, 0, 0, 0);
    add_row(OP_TRAIN, {8'd200, 8'd240, 8'd250, 8'd250, 8'd250, 8'd250}, 1'b0, 0, 0, 0, 0);
    // largest distance: both prototypes at full scale, sample at zero
    add_row(OP_LOAD, {6{8'd255}}, 1'b0, 1, 0, 0, 0);
    add_row(OP_LOAD, {6{8'd255}}, 1'b1, 1, 0, 0, 0);
    add_row(OP_CLASSIFY, {6{8'd0}}, 1'b1, 1, 0, 0, 390150);
    add_row(OP_TRAIN, {6{8'd0}}, 1'b0, 0, 0, 0, 0);
    add_row(OP_TRAIN, {6{8'd0}}, 1'b1, 0, 0, 0, 0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_txn(directed_rows[i]);

    for (int ph = 0; ph < 5; ph++) begin
      @(negedge clk);
      in_valid <= 1'b0;
      wait_for_drain();
      write_reg(CFG_LR_INIT, phase_init[ph]);
      write_reg(CFG_KEEP, phase_keep[ph]);
      for (int n = 0; n < 400; n++) begin
        if ($urandom_range(0, 199) == 0) begin
          @(negedge clk);
          in_valid <= 1'b0;
          wait_for_drain();
        end
        send_txn(random_item());
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
src/lvq_pkg.sv
src/lvq_lane.sv
src/lvq_merge.sv
src/lvq_nearest_prototype_trainer.sv
test/lvq_nearest_prototype_trainer_tb.sv
